### sv/srpg_pkg.sv
// Package: shared types and constants of the stepper ramp period generator
package srpg_pkg;

  localparam logic [31:0] QMAX          = 32'h7FFF_FFFF;
  localparam logic [8:0]  TENTH_MILLI   = 9'd419;
  localparam logic [28:0] TEN_THOUSAND  = 29'd327680000;

  localparam logic [1:0] REG_STEP_LENGTH = 2'd0;
  localparam logic [1:0] REG_TICK_LENGTH = 2'd1;
  localparam logic [1:0] REG_PERIOD_MIN  = 2'd2;
  localparam logic [1:0] REG_PERIOD_MAX  = 2'd3;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_PRD_S22,
    OP_INV_START,
    OP_RATE,
    OP_PER_TICK,
    OP_DIST,
    OP_VEL,
    OP_ACC_D,
    OP_SQ5,
    OP_RAD,
    OP_SQRT_START,
    OP_DQ22,
    OP_PQ22_START,
    OP_PRD,
    OP_CLAMP,
    OP_H12,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  // saturate to the largest positive 32-bit Q value
  function automatic logic [31:0] sat31(input logic [63:0] v);
    sat31 = (v > 64'(QMAX)) ? QMAX : v[31:0];
  endfunction

endpackage

### sv/stepper_ramp_period_generator.sv
// Top level: stepper ramp period generator, registers, handshake and output beat
//
// channel | direction | payload
// s_axis  | in        | tdata = speed_goal[27:0], target_accel[57:28],
//         |           |         handle_gain[87:58]; tuser = run
// m_axis  | out       | tdata = pwm_period, pwm_compare, next_velocity, distance_total
// cfg     | in        | cfg_we, cfg_addr, cfg_data (31 bits)
//
// A run beat loads its result after 16 operation steps, two 64-step restoring
// divisions and a 19-step square root; the controller then returns to idle
// before it takes the next beat.
// A beat with run low is taken while idle and gives no result. Reset is
// synchronous. The next beat is accepted while a finished result waits in the
// output register; a second finished result stalls until that register frees.
module stepper_ramp_period_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,  // speed_goal, target_accel, handle_gain
  input  logic         s_axis_tuser,  // run
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // pwm_period, pwm_compare, next_velocity, distance_total
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_data
);
  import srpg_pkg::*;

  logic [30:0] step_length;
  logic [21:0] tick_length;
  logic [15:0] period_min, period_max;
  cmd_t        cmd;
  stat_t       stat;
  logic        ready_c, load_out, start, accept;
  logic [15:0] pwm;
  logic [27:0] nv;
  logic [31:0] dist_total;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= 31'd4194304;
      tick_length <= 22'd4194;
      period_min  <= 16'd7000;
      period_max  <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP_LENGTH: step_length <= cfg_data;
        REG_TICK_LENGTH: tick_length <= cfg_data[21:0];
        REG_PERIOD_MIN:  period_min  <= cfg_data[15:0];
        REG_PERIOD_MAX:  period_max  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ready_c;
  assign accept = s_axis_tvalid & ready_c;
  assign start  = accept & s_axis_tuser;

  srpg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .cmd(cmd), .in_ready(ready_c), .load_out(load_out)
  );

  srpg_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .start(start),
    .speed_goal(s_axis_tdata[27:0]),
    .target_accel(s_axis_tdata[57:28]),
    .handle_gain(s_axis_tdata[87:58]),
    .step_length(step_length), .tick_length(tick_length),
    .period_min(period_min), .period_max(period_max),
    .stat(stat), .pwm_period(pwm), .next_velocity(nv), .distance_total(dist_total)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {4'd0, dist_total, nv, 16'(pwm[15:1]) + 16'(pwm[15:2]), pwm};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

### sv/srpg_ctrl.sv
// Controller: sequences the datapath operations for one tick
module srpg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  srpg_pkg::stat_t stat,
  input  logic            out_free,
  output srpg_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            load_out
);
  import srpg_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  // hold state and current operation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_NONE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // advance through the operation list, wait on the iterative units
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (start) begin
          state_next = S_STEP;
          op_next    = OP_PRD_S22;
        end
      end
      S_STEP: begin
        cmd.op = op;
        if (op == OP_INV_START || op == OP_SQRT_START || op == OP_PQ22_START) begin
          state_next = S_WAIT;
        end else if (op == OP_FINISH) begin
          state_next = S_OUT;
        end
        op_next = op_t'(op + 5'd1);
        if (op == OP_FINISH) op_next = OP_NONE;
      end
      S_WAIT: begin
        if (!stat.busy) state_next = S_STEP;
      end
      S_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/srpg_datapath.sv
// Datapath: registers, multiplier, divider and square root of the ramp
module srpg_datapath (
  input  logic            clk,
  input  logic            rst,
  input  srpg_pkg::cmd_t  cmd,
  input  logic            start,
  input  logic [27:0]     speed_goal,
  input  logic [29:0]     target_accel,
  input  logic [29:0]     handle_gain,
  input  logic [30:0]     step_length,
  input  logic [21:0]     tick_length,
  input  logic [15:0]     period_min,
  input  logic [15:0]     period_max,
  output srpg_pkg::stat_t stat,
  output logic [15:0]     pwm_period,
  output logic [27:0]     next_velocity,
  output logic [31:0]     distance_total
);
  import srpg_pkg::*;

  logic [27:0] tgt_v;
  logic [29:0] acc, gain;
  logic [31:0] next_period, travelled;
  logic [31:0] prd_s22, inv, rate, per_tick, dist22, vel, acc_d, sq5, rad, nvel;
  logic [31:0] dq22, pq22, prd, handle;
  logic [31:0] pmin15, pmax15;
  logic [51:0] h12;

  // shared 32x32 multiplier: operands chosen by the operation
  logic [31:0] ma, mb;
  logic [63:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_PRD_S22:  begin ma = 32'(TENTH_MILLI); mb = next_period; end
      OP_RATE:     begin ma = inv; mb = 32'(TEN_THOUSAND); end
      OP_PER_TICK: begin ma = 32'(tick_length); mb = rate; end
      OP_DIST:     begin ma = 32'(step_length); mb = per_tick; end
      OP_VEL:      begin ma = {7'd0, dist22[31:7]}; mb = rate; end
      OP_ACC_D:    begin ma = {7'd0, dist22[31:7]}; mb = 32'(acc); end
      OP_SQ5:      begin ma = {10'd0, vel[31:10]}; mb = {10'd0, vel[31:10]}; end
      OP_DQ22:     begin ma = nvel; mb = 32'(TENTH_MILLI); end
      OP_PRD:      begin ma = 32'(TEN_THOUSAND); mb = pq22; end
      OP_H12:      begin ma = {3'd0, prd[31:3]}; mb = 32'(gain); end
      default:     begin ma = '0; mb = '0; end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  // shared restoring divider: 64-bit numerator, one quotient bit a cycle
  logic [63:0] dv_num, dv_quo;
  logic [63:0] dv_rem;
  logic [31:0] dv_den;
  logic [6:0]  dv_cnt;
  logic        dv_busy, dv_sel;
  logic [64:0] dv_trial;
  assign dv_trial = {dv_rem[63:0], dv_num[63]} - 65'(dv_den);

  // square root: iterative, holds busy until the root is done
  logic [36:0] sq_x, sq_r, sq_bit;
  logic        sq_busy;
  logic [37:0] sq_sum;
  assign sq_sum = 38'(sq_r) + 38'(sq_bit);

  logic [31:0] acc_d10;
  assign acc_d10 = {10'd0, acc_d[31:10]};
  assign pmin15  = {1'b0, period_min, 15'd0};
  assign pmax15  = {1'b0, period_max, 15'd0};
  assign stat.busy = dv_busy | sq_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_period <= {1'b0, 16'hFFFF, 15'd0};
      travelled   <= '0;
      dv_busy     <= 1'b0;
      sq_busy     <= 1'b0;
    end else begin
      // hold the item
      if (start) begin
        tgt_v <= speed_goal;
        acc   <= target_accel;
        gain  <= handle_gain;
      end
      case (cmd.op)
        OP_PRD_S22: prd_s22 <= sat31(prod >> 15);
        OP_INV_START: begin
          dv_sel  <= 1'b0;
          dv_num  <= 64'd1 << 30;
          dv_den  <= {7'd0, prd_s22[31:7]};
          dv_rem  <= '0;
          dv_cnt  <= 7'd64;
          dv_busy <= 1'b1;
        end
        OP_RATE:     rate <= sat31(prod >> 15);
        OP_PER_TICK: per_tick <= sat31(prod >> 15);
        OP_DIST:     dist22 <= sat31(prod >> 22);
        OP_VEL:      vel <= sat31(prod >> 15);
        OP_ACC_D:    acc_d <= sat31((prod >> 15) << 1);
        OP_SQ5:      sq5 <= sat31(prod >> 5);
        OP_RAD: begin
          if (vel < 32'(tgt_v)) rad <= sat31(64'(sq5) + 64'(acc_d10));
          else rad <= (sq5 >= acc_d10) ? sq5 - acc_d10 : 32'd0;
        end
        OP_SQRT_START: begin
          sq_x    <= {rad, 5'd0};
          sq_r    <= '0;
          sq_bit  <= 37'd1 << 36;
          sq_busy <= 1'b1;
        end
        OP_DQ22: dq22 <= sat31(prod >> 15);
        OP_PQ22_START: begin
          dv_sel  <= 1'b1;
          dv_num  <= {10'd0, dist22, 22'd0};
          dv_den  <= dq22;
          dv_rem  <= '0;
          dv_cnt  <= 7'd64;
          dv_busy <= 1'b1;
        end
        OP_PRD: prd <= sat31(prod >> 22);
        OP_CLAMP: begin
          if (prd < pmin15) prd <= pmin15;
          else if (prd > pmax15) prd <= pmax15;
        end
        OP_H12: begin
          next_period <= prd;
          h12 <= 52'(prod >> 28);
        end
        OP_FINISH: begin
          if (h12 > 52'({period_max, 12'd0})) handle <= pmax15;
          else if (h12 < 52'({period_min, 12'd0})) handle <= pmin15;
          else handle <= {h12[28:0], 3'd0};
          travelled <= travelled + {5'd0, dist22[31:5]};
        end
        default: ;
      endcase

      // divider iteration
      if (dv_busy) begin
        if (dv_cnt == 7'd0) begin
          dv_busy <= 1'b0;
          if (dv_sel) pq22 <= (dv_den == '0) ? QMAX : sat31(dv_quo);
          else inv <= (dv_den == '0) ? QMAX : sat31(dv_quo);
        end else begin
          dv_cnt <= dv_cnt - 7'd1;
          dv_num <= dv_num << 1;
          if (!dv_trial[64]) begin
            dv_rem <= dv_trial[63:0];
            dv_quo <= {dv_quo[62:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[62:0], dv_num[63]};
            dv_quo <= {dv_quo[62:0], 1'b0};
          end
        end
      end

      // square root iteration
      if (sq_busy) begin
        if (sq_bit == '0) begin
          sq_busy <= 1'b0;
          nvel    <= {sq_r[21:0], 10'd0};
        end else begin
          if (38'(sq_x) >= sq_sum) begin
            sq_x <= sq_x - sq_sum[36:0];
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
    end
  end

  assign pwm_period     = handle[30:15];
  assign next_velocity  = nvel[27:0];
  assign distance_total = travelled;

endmodule

### bench/stepper_ramp_period_generator_tb.sv
// Testbench for the stepper ramp period generator: ramp prediction and result checks
`timescale 1ns / 1ps

module stepper_ramp_period_generator_tb;
  import srpg_pkg::*;

  localparam logic [31:0] QTOP = 32'h7FFF_FFFF;

  // ramp predictor and store of expected PWM beats
  class ramp_scoreboard;
    logic [30:0] step_len;
    logic [21:0] tick_len;
    logic [15:0] pmin, pmax;
    logic [31:0] period_q15, distance_q17;
    logic [95:0] pending[$];
    int errors;

    function void reset_state();
      step_len = 31'd4194304; tick_len = 22'd4194;
      pmin = 16'd7000; pmax = 16'd65535;
      period_q15 = 32'(pmax) << 15; distance_q17 = 0;
      pending.delete(); errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        REG_STEP_LENGTH: step_len = val;
        REG_TICK_LENGTH: tick_len = val[21:0];
        REG_PERIOD_MIN:  pmin = val[15:0];
        REG_PERIOD_MAX:  pmax = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] clip(logic [63:0] v);
      return (v > 64'(QTOP)) ? QTOP : v[31:0];
    endfunction

    function logic [31:0] divide(logic [63:0] n, logic [63:0] d);
      return (d == 0) ? QTOP : clip(n / d);
    endfunction

    function logic [63:0] root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_tick(logic runb, logic [27:0] tv, logic [29:0] acc, logic [29:0] gain);
      logic [31:0] ps, inv, rate, pt, d22, vel, ad, vq, sq, rad, nv, dq, pq, prd, lo, hi, hd;
      logic [63:0] h12;
      logic [15:0] pwm;
      if (!runb) return;
      ps = clip((64'd419 * period_q15) >> 15);
      inv = divide(64'd32768 << 15, 64'(ps >> 7));
      rate = clip((64'(inv) * 64'd327680000) >> 15);
      pt = clip((64'(tick_len) * rate) >> 15);
      d22 = clip((64'(step_len) * pt) >> 22);
      vel = clip((64'(d22 >> 7) * rate) >> 15);
      ad = clip(((64'(d22 >> 7) * acc) >> 15) << 1);
      vq = vel >> 10;
      sq = clip((64'(vq) * vq) >> 5);
      if (vel < 32'(tv)) rad = clip(64'(sq) + (ad >> 10));
      else rad = (sq >= (ad >> 10)) ? sq - (ad >> 10) : 0;
      nv = 32'(root(64'(rad) << 5)) << 10;
      dq = clip((64'(nv) * 419) >> 15);
      pq = divide(64'(d22) << 22, 64'(dq));
      prd = clip((64'd327680000 * pq) >> 22);
      lo = 32'(pmin) << 15; hi = 32'(pmax) << 15;
      if (prd < lo) prd = lo;
      else if (prd > hi) prd = hi;
      period_q15 = prd;
      h12 = (64'(prd >> 3) * gain) >> 28;
      if (h12 > (64'(pmax) << 12)) hd = hi;
      else if (h12 < (64'(pmin) << 12)) hd = lo;
      else hd = 32'(h12 << 3);
      distance_q17 += d22 >> 5;
      pwm = hd[30:15];
      pending.push_back({4'd0, distance_q17, nv[27:0], (pwm >> 1) + (pwm >> 2), pwm});
    endfunction

    function void check_beat(logic [95:0] got);
      logic [95:0] exp_beat;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      exp_beat = pending.pop_front();
      if (got[15:0] !== exp_beat[15:0]) begin
        $display("%0t: pwm_period exp %0d got %0d", $time, exp_beat[15:0], got[15:0]);
        errors++;
      end
      if (got[31:16] !== exp_beat[31:16]) begin
        $display("%0t: pwm_compare exp %0d got %0d", $time, exp_beat[31:16], got[31:16]);
        errors++;
      end
      if (got[59:32] !== exp_beat[59:32]) begin
        $display("%0t: next_velocity exp %h got %h", $time, exp_beat[59:32], got[59:32]);
        errors++;
      end
      if (got[95:60] !== exp_beat[95:60]) begin
        $display("%0t: distance_total exp %h got %h", $time, exp_beat[95:60], got[95:60]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
  logic [87:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [95:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [30:0] cfg_data = '0;

  int send_idle, recv_idle;
  int phase_idx = -1;
  logic hold_off = 1'b0;
  ramp_scoreboard ramp;

  stepper_ramp_period_generator u_top (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #80ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // long receiver hold-off during the back-to-back phase
  initial begin
    wait (phase_idx == 6);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // receiver: random stall plus the long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) ramp.check_beat(m_axis_tdata);
      if (hold_off) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    ramp.write_reg(idx, val);
  endtask

  // offer one tick and hold it until taken
  task automatic send_tick(logic runb, logic [27:0] tv, logic [29:0] acc, logic [29:0] gain);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= runb;
    s_axis_tdata <= {gain, acc, tv};
    do @(posedge clk); while (!s_axis_tready);
    ramp.note_tick(runb, tv, acc, gain);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ramp.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_ticks(int count);
    logic [27:0] tv;
    logic [29:0] acc, gain;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: tv = 28'($urandom);
        1: tv = '1;
        default: tv = 28'($urandom_range(2000000));
      endcase
      acc = ($urandom_range(3) == 0) ? 30'($urandom) : 30'($urandom_range(4000000));
      case ($urandom_range(3))
        0: gain = 30'($urandom);
        default: gain = 30'((32'd1 << 28) + $urandom_range(8000000) - 32'd4000000);
      endcase
      send_tick($urandom_range(15) != 0, tv, acc, gain);
    end
  endtask

  initial begin
    ramp = new();
    ramp.reset_state();
    send_idle = 10; recv_idle = 48;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and special cases at reset settings
    send_tick(1'b0, '1, '1, '1);
    send_tick(1'b1, '0, '0, 30'd1 << 28);
    send_tick(1'b1, '1, '1, 30'd1 << 28);
    send_tick(1'b1, '1, 30'd100000, 30'd1 << 28);
    send_tick(1'b1, '1, '1, '1);
    send_tick(1'b1, '0, '1, '0);
    send_tick(1'b1, '0, '1, 30'd1 << 28);
    send_tick(1'b1, 28'd1000000, 30'd500000, 30'h2AAAAAAA);
    send_tick(1'b1, 28'd1000000, 30'd500000, 30'h15555555);
    drain();
    // min above max, then zero step length, then extremes
    write_reg(REG_PERIOD_MIN, 31'd40000);
    write_reg(REG_PERIOD_MAX, 31'd20000);
    send_tick(1'b1, '1, '1, 30'd1 << 28);
    send_tick(1'b1, '0, '1, 30'd1 << 27);
    drain();
    write_reg(REG_STEP_LENGTH, 31'd0);
    write_reg(REG_TICK_LENGTH, 31'h3FFFFF);
    write_reg(REG_PERIOD_MIN, 31'd1);
    write_reg(REG_PERIOD_MAX, 31'd65535);
    send_tick(1'b1, '1, '1, 30'd1 << 28);
    send_tick(1'b1, '0, '1, 30'd1 << 28);
    drain();
    write_reg(REG_STEP_LENGTH, 31'h7FFFFFFF);
    write_reg(REG_TICK_LENGTH, 31'd0);
    send_tick(1'b1, '1, '1, 30'd1 << 28);
    drain();
    write_reg(REG_STEP_LENGTH, 31'h55555555);
    write_reg(REG_TICK_LENGTH, 31'h2AAAAA);
    write_reg(REG_PERIOD_MIN, 31'hAAAA);
    write_reg(REG_PERIOD_MAX, 31'hFFFF);
    send_tick(1'b1, '1, '1, '1);
    send_tick(1'b1, '0, 30'h2AAAAAAA, 30'h15555555);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_STEP_LENGTH, ph[0] ? 31'($urandom_range(8388608)) : 31'($urandom));
      write_reg(REG_TICK_LENGTH,
                ph[1] ? 31'($urandom_range(20000)) : 31'($urandom_range(4194303)));
      write_reg(REG_PERIOD_MIN, 31'($urandom_range(1, 20000)));
      write_reg(REG_PERIOD_MAX, 31'($urandom_range(15000, 65535)));
      if (ph < 3) begin
        send_idle = 10; recv_idle = 48;
      end else if (ph < 6) begin
        send_idle = 48; recv_idle = 10;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      phase_idx = ph;
      random_ticks(200);
      drain();
    end

    if (ramp.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### sim.f
sv/srpg_pkg.sv
sv/srpg_ctrl.sv
sv/srpg_datapath.sv
sv/stepper_ramp_period_generator.sv
bench/stepper_ramp_period_generator_tb.sv
